// ===== hdl/fsbc_pkg.sv =====
// Shared types and constants for the frustum sphere/box culling block.
package fsbc_pkg;

   // Number of plane registers on the configuration port.
   localparam int REG_COUNT = 6;
   // Default number of planes in the chain.
   localparam int PLANE_COUNT_DEF = 6;
   // Configuration port widths.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 64;
   // Coordinate and coefficient widths.
   localparam int COORD_W = 16;
   localparam int RADIUS_W = 15;
   localparam int PROD_W = 32;
   // Exact plane distance in Q.22 fits in 33 signed bits; 34 are kept.
   localparam int DIST_W = 34;
   localparam int DEPTH_W = 20;
   localparam int VERDICT_W = 2;
   localparam int FRAC_SHIFT = 14;

   // Verdict codes.
   localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_PARTIAL = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_INSIDE = 2'd2;

   // Function codes.
   localparam logic FUNC_SPHERE = 1'b0;
   localparam logic FUNC_BOX = 1'b1;

   // One bounding volume as it travels down the chain.
   typedef struct packed {
      logic                       func;
      logic signed [COORD_W-1:0]  ax;
      logic signed [COORD_W-1:0]  ay;
      logic signed [COORD_W-1:0]  az;
      logic signed [COORD_W-1:0]  bx;
      logic signed [COORD_W-1:0]  by;
      logic signed [COORD_W-1:0]  bz;
      logic [RADIUS_W-1:0]        radius;
   } item_type;

   // Running classification gathered plane by plane.
   typedef struct packed {
      logic outside;   // sphere reached or crossed a plane from the back
      logic all_in;    // sphere clear of every plane so far
      logic visible;   // box has a corner in front of every plane so far
   } flags_type;

endpackage

// ===== hdl/fsbc_cell.sv =====
// One plane cell of the culling chain: holds a plane and tests each passing word against it.
module fsbc_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                csr_we,
   input  logic [fsbc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fsbc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                in_valid,
   input  fsbc_pkg::item_type                  in_item,
   input  fsbc_pkg::flags_type                 in_flags,
   output logic                                out_valid,
   output fsbc_pkg::item_type                  out_item,
   output fsbc_pkg::flags_type                 out_flags,
   output logic signed [fsbc_pkg::DIST_W-1:0]  out_dist
);
   import fsbc_pkg::*;

   logic [CSR_DATA_W-1:0] plane;
   logic signed [COORD_W-1:0] nx, ny, nz, dofs;
   logic signed [COORD_W-1:0] sel_x, sel_y, sel_z;
   logic is_box;

   logic signed [PROD_W-1:0] prod_x_ff, prod_x_in;
   logic signed [PROD_W-1:0] prod_y_ff, prod_y_in;
   logic signed [PROD_W-1:0] prod_z_ff, prod_z_in;
   item_type  mid_item_ff;
   flags_type mid_flags_ff;
   logic      mid_valid_ff;

   logic signed [DIST_W-1:0] dist_in, dist_ff;
   logic signed [DIST_W-1:0] r22, neg_r22;
   flags_type flags_in, flags_ff;
   item_type  item_ff;
   logic      valid_ff;

   // Plane register; cells past the register file see an all-zero plane.
   generate
      if (CELL_INDEX < REG_COUNT) begin : g_reg
         logic [CSR_DATA_W-1:0] plane_ff, plane_in;
         always_comb begin
            plane_in = plane_ff;
            if (csr_we && csr_index == CSR_INDEX_W'(CELL_INDEX)) begin
               plane_in = csr_wdata;
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               plane_ff <= '0;
            end else begin
               plane_ff <= plane_in;
            end
         end
         assign plane = plane_ff;
      end else begin : g_zero
         assign plane = '0;
      end
   endgenerate

   assign nx   = plane[15:0];
   assign ny   = plane[31:16];
   assign nz   = plane[47:32];
   assign dofs = plane[63:48];

   // Box mode takes the corner farthest along the normal, one axis at a time.
   assign is_box = (in_item.func == FUNC_BOX);

   always_comb begin
      sel_x = in_item.ax;
      sel_y = in_item.ay;
      sel_z = in_item.az;
      if (is_box) begin
         if (nx[COORD_W-1] != (in_item.bx > in_item.ax)) begin
            sel_x = in_item.bx;
         end
         if (ny[COORD_W-1] != (in_item.by > in_item.ay)) begin
            sel_y = in_item.by;
         end
         if (nz[COORD_W-1] != (in_item.bz > in_item.az)) begin
            sel_z = in_item.bz;
         end
      end
   end

   assign prod_x_in = nx * sel_x;
   assign prod_y_in = ny * sel_y;
   assign prod_z_in = nz * sel_z;

   // First stage: the three products.
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (advance) begin
         mid_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_x_ff    <= prod_x_in;
         prod_y_ff    <= prod_y_in;
         prod_z_ff    <= prod_z_in;
         mid_item_ff  <= in_item;
         mid_flags_ff <= in_flags;
      end
   end

   // Second stage: sum to the exact distance and update the classification.
   assign r22 = {{(DIST_W-RADIUS_W-FRAC_SHIFT){1'b0}}, mid_item_ff.radius,
                 {FRAC_SHIFT{1'b0}}};
   assign neg_r22 = -r22;
   assign dist_in = {{(DIST_W-PROD_W){prod_x_ff[PROD_W-1]}}, prod_x_ff}
                  + {{(DIST_W-PROD_W){prod_y_ff[PROD_W-1]}}, prod_y_ff}
                  + {{(DIST_W-PROD_W){prod_z_ff[PROD_W-1]}}, prod_z_ff}
                  + {{(DIST_W-COORD_W-FRAC_SHIFT){dofs[COORD_W-1]}}, dofs,
                     {FRAC_SHIFT{1'b0}}};

   always_comb begin
      flags_in = mid_flags_ff;
      if (mid_item_ff.func == FUNC_BOX) begin
         if (!(dist_in > 0)) begin
            flags_in.visible = 1'b0;
         end
      end else begin
         if (dist_in <= neg_r22) begin
            flags_in.outside = 1'b1;
         end
         if (!(dist_in > r22)) begin
            flags_in.all_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dist_ff  <= dist_in;
         flags_ff <= flags_in;
         item_ff  <= mid_item_ff;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_flags = flags_ff;
   assign out_dist  = dist_ff;

endmodule

// ===== hdl/frustum_sphere_box_cull.sv =====
// Top level of the frustum culling block: plane cell chain and result register.
//
// Usage: load the planes through the csr_ port (index 0 right, 1 left,
// 2 bottom, 3 top, 4 far, 5 near; nx, ny, nz Q1.14 and d Q8.8, 16 bits each
// from the low end). Writes take effect at once and should be made while no
// word is in flight. Bounding volumes enter on req_ (tuser selects sphere or
// box), one classification per word leaves on rsp_.
// Each plane cell has a product stage and a sum/compare stage, and the result
// register follows the last cell; the first product stage loads at the
// accepting edge. Throughput: one word per cycle while the receiver does not
// stall, set by the pipelined cell chain.
// Reset clears all planes to zero and drops every word in flight.
// When the receiver stalls with a result waiting, the whole chain holds and
// req_tready falls; it returns as soon as the result is taken.
module frustum_sphere_box_cull #(
   parameter int PLANE_COUNT = fsbc_pkg::PLANE_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input words.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [111:0]                        req_tdata,  // ax, ay, az, bx, by, bz, radius, pad
   input  logic                                req_tuser,  // func
   // Result words.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [23:0]                         rsp_tdata,  // verdict, depth, pad
   // Plane configuration.
   input  logic                                csr_we,
   input  logic [fsbc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fsbc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import fsbc_pkg::*;

   localparam logic signed [DEPTH_W:0] SAT_MAX = (DEPTH_W+1)'(524287);
   localparam logic signed [DEPTH_W:0] SAT_MIN = -(DEPTH_W+1)'(524288);

   logic advance;
   item_type  req_item;
   flags_type init_flags;

   logic      chain_valid [0:PLANE_COUNT];
   item_type  chain_item  [0:PLANE_COUNT];
   flags_type chain_flags [0:PLANE_COUNT];
   logic signed [DIST_W-1:0] chain_dist [1:PLANE_COUNT];

   item_type  last_item;
   flags_type last_flags;
   logic signed [DIST_W-1:0] last_dist;
   logic signed [DIST_W:0] depth_sum;
   logic signed [DEPTH_W:0] depth_q;
   logic signed [DEPTH_W-1:0] depth_sat;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [VERDICT_W-1:0]       verdict_ff, verdict_in;
   logic signed [DEPTH_W-1:0]  depth_ff, depth_in;

   // The chain moves whenever the result register is free or being emptied.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // Unpack the input word.
   always_comb begin
      req_item.func   = req_tuser;
      req_item.ax     = req_tdata[15:0];
      req_item.ay     = req_tdata[31:16];
      req_item.az     = req_tdata[47:32];
      req_item.bx     = req_tdata[63:48];
      req_item.by     = req_tdata[79:64];
      req_item.bz     = req_tdata[95:80];
      req_item.radius = req_tdata[110:96];
   end

   always_comb begin
      init_flags.outside = 1'b0;
      init_flags.all_in  = 1'b1;
      init_flags.visible = 1'b1;
   end

   assign chain_valid[0] = req_tvalid;
   assign chain_item[0]  = req_item;
   assign chain_flags[0] = init_flags;

   // One cell per plane.
   generate
      for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
         fsbc_cell #(
            .CELL_INDEX(i)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .advance   (advance),
            .csr_we    (csr_we),
            .csr_index (csr_index),
            .csr_wdata (csr_wdata),
            .in_valid  (chain_valid[i]),
            .in_item   (chain_item[i]),
            .in_flags  (chain_flags[i]),
            .out_valid (chain_valid[i+1]),
            .out_item  (chain_item[i+1]),
            .out_flags (chain_flags[i+1]),
            .out_dist  (chain_dist[i+1])
         );
      end
   endgenerate

   assign last_item  = chain_item[PLANE_COUNT];
   assign last_flags = chain_flags[PLANE_COUNT];
   assign last_dist  = chain_dist[PLANE_COUNT];

   // Depth: last plane distance plus radius, floored to Q12.8 and saturated.
   assign depth_sum = {last_dist[DIST_W-1], last_dist}
                    + (DIST_W+1)'({last_item.radius, {FRAC_SHIFT{1'b0}}});
   assign depth_q   = depth_sum[DIST_W:FRAC_SHIFT];

   always_comb begin
      if (depth_q > SAT_MAX) begin
         depth_sat = SAT_MAX[DEPTH_W-1:0];
      end else if (depth_q < SAT_MIN) begin
         depth_sat = SAT_MIN[DEPTH_W-1:0];
      end else begin
         depth_sat = depth_q[DEPTH_W-1:0];
      end
   end

   // Final classification.
   always_comb begin
      verdict_in = VERDICT_OUTSIDE;
      depth_in   = '0;
      if (last_item.func == FUNC_BOX) begin
         if (last_flags.visible) begin
            verdict_in = VERDICT_PARTIAL;
         end
      end else if (!last_flags.outside) begin
         verdict_in = last_flags.all_in ? VERDICT_INSIDE : VERDICT_PARTIAL;
         depth_in   = depth_sat;
      end
   end

   // Result register.
   assign rsp_valid_in = advance ? chain_valid[PLANE_COUNT] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         verdict_ff <= verdict_in;
         depth_ff   <= depth_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, depth_ff, verdict_ff};

   // A verdict code outside the defined set never leaves the block.
   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == VERDICT_OUTSIDE
                      || rsp_tdata[1:0] == VERDICT_PARTIAL
                      || rsp_tdata[1:0] == VERDICT_INSIDE))
      else $error("illegal verdict code");

   // An outside verdict carries zero depth.
   a_outside_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] == VERDICT_OUTSIDE) |-> (rsp_tdata[21:2] == '0))
      else $error("outside verdict with nonzero depth");

   // A sphere fully inside has a non-negative depth.
   a_inside_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] == VERDICT_INSIDE) |-> !rsp_tdata[21])
      else $error("inside verdict with negative depth");

   // No result is presented right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule
